>>> rtl/sorted_priority_queue_defines.svh
// Assertion macros shared by the sorted priority queue checkers.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_W           = 16;
  localparam int PAY_W           = 16;
  localparam int OP_W            = 2;
  localparam int CNT_OUT_W       = 5;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic compare;
    logic update;
    logic report;
  } spq_cmd_t;

endpackage

>>> rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue.
//
// Bounded priority queue held as a row of QUEUE_DEPTH sorted cells. Pulse
// start with busy low to hand in one operation beat (insert, remove head,
// clear); an unused operation code changes nothing. Each cell compares its
// key with the new key in parallel, then all cells shift together. Each
// operation runs from the accepting edge to the result through the steps
// latch, compare, update and report, stepped by the controller
// state machine. The result beat appears on the out_ ports with out_valid
// high for one cycle only and cannot be stalled; capture it then. busy is
// already low during that cycle, so the next operation may start there.
// sort_descending is written through the cfg_ port (always ready) and
// must only change while the queue is idle; stored entries are not
// re-sorted. No clearing pass is needed after reset.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  spq_pkg::op_t                  in_operation,
  input  logic [spq_pkg::KEY_W-1:0]     in_key,
  input  logic [spq_pkg::PAY_W-1:0]     in_payload,
  output logic                          out_valid,
  output logic                          out_head_valid,
  output logic [spq_pkg::KEY_W-1:0]     out_head_key,
  output logic [spq_pkg::PAY_W-1:0]     out_head_payload,
  output logic [spq_pkg::CNT_OUT_W-1:0] out_entry_count,
  output logic                          out_insert_dropped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_sort_descending
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  // Configuration is a single register: take every write beat at once.
  assign cfg_ready = 1'b1;

  // Sequence each operation beat.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Hold the sorted cells and build the result beat.
  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_operation        (in_operation),
    .in_key              (in_key),
    .in_payload          (in_payload),
    .cfg_valid           (cfg_valid && cfg_ready),
    .cfg_sort_descending (cfg_sort_descending),
    .out_head_valid      (out_head_valid),
    .out_head_key        (out_head_key),
    .out_head_payload    (out_head_payload),
    .out_entry_count     (out_entry_count),
    .out_insert_dropped  (out_insert_dropped)
  );

endmodule

>>> rtl/spq_ctrl.sv
// Controller state machine of the sorted priority queue.
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_RPT
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_CMP;
            busy_r  <= 1'b1;
          end
        end
        S_CMP: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          state_r <= S_RPT;
        end
        S_RPT: begin
          state_r     <= S_IDLE;
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == S_IDLE) && start;
    cmd.compare = (state_r == S_CMP);
    cmd.update  = (state_r == S_UPD);
    cmd.report  = (state_r == S_RPT);
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/spq_datapath.sv
// Entry cells, per-cell comparators and result registers of the queue.
module spq_datapath #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spq_pkg::spq_cmd_t             cmd,
  input  spq_pkg::op_t                  in_operation,
  input  logic [spq_pkg::KEY_W-1:0]     in_key,
  input  logic [spq_pkg::PAY_W-1:0]     in_payload,
  input  logic                          cfg_valid,
  input  logic                          cfg_sort_descending,
  output logic                          out_head_valid,
  output logic [spq_pkg::KEY_W-1:0]     out_head_key,
  output logic [spq_pkg::PAY_W-1:0]     out_head_payload,
  output logic [spq_pkg::CNT_OUT_W-1:0] out_entry_count,
  output logic                          out_insert_dropped
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LV = $clog2(QUEUE_DEPTH);

  logic                   desc_r;
  op_t                    op_r;
  logic [KEY_W-1:0]       new_key_r;
  logic [PAY_W-1:0]       new_pay_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic [QUEUE_DEPTH-1:0] before_r;
  logic [KEY_W-1:0]       key_r [QUEUE_DEPTH];
  logic [PAY_W-1:0]       pay_r [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] pfx [LV+1];
  logic                   full;
  logic                   empty;
  logic                   dropped_r;
  logic                   head_valid_r;
  logic [KEY_W-1:0]       head_key_r;
  logic [PAY_W-1:0]       head_pay_r;
  logic [CW+CNT_OUT_W-1:0] count_ext;

  assign full  = (count_r == CW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  // Sort order register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
    end else if (cfg_valid) begin
      desc_r <= cfg_sort_descending;
    end
  end

  // Latch the operation beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_operation;
      new_key_r <= in_key;
      new_pay_r <= in_payload;
    end
  end

  // Each cell checks whether its stored key orders strictly before the new key.
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        before_r[i] <= (CW'(i) < count_r) &&
                       (desc_r ? (key_r[i] > new_key_r) : (key_r[i] < new_key_r));
      end
    end
  end

  // Parallel prefix OR: pfx[LV][i] is set from the insert slot onward.
  always_comb begin
    pfx[0] = ~before_r;
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (i >= (1 << l)) begin
          pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
        end else begin
          pfx[l+1][i] = pfx[l][i];
        end
      end
    end
  end

  // Cell update: insert shifts toward the tail, remove shifts toward the head.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (op_r == OP_INSERT && !full) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (pfx[LV][i]) begin
            if (i == 0) begin
              key_r[i] <= new_key_r;
              pay_r[i] <= new_pay_r;
            end else if (!pfx[LV][(i > 0) ? i - 1 : 0]) begin
              key_r[i] <= new_key_r;
              pay_r[i] <= new_pay_r;
            end else begin
              key_r[i] <= key_r[(i > 0) ? i - 1 : 0];
              pay_r[i] <= pay_r[(i > 0) ? i - 1 : 0];
            end
          end
        end
      end else if (op_r == OP_REMOVE && !empty) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          key_r[i] <= key_r[i + 1];
          pay_r[i] <= pay_r[i + 1];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    case (op_r)
      OP_INSERT: if (!full)  count_nxt = count_r + CW'(1);
      OP_REMOVE: if (!empty) count_nxt = count_r - CW'(1);
      OP_CLEAR:  count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.update) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      dropped_r <= (op_r == OP_INSERT) && full;
    end
  end

  // Result registers; an empty queue reports zeros.
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      head_valid_r <= !empty;
      head_key_r   <= empty ? '0 : key_r[0];
      head_pay_r   <= empty ? '0 : pay_r[0];
    end
  end

  assign count_ext          = {{CNT_OUT_W{1'b0}}, count_r};
  assign out_head_valid     = head_valid_r;
  assign out_head_key       = head_key_r;
  assign out_head_payload   = head_pay_r;
  assign out_entry_count    = count_ext[CNT_OUT_W-1:0];
  assign out_insert_dropped = dropped_r;

endmodule

>>> rtl/spq_checker.sv
// Port-level checker of the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_defines.svh"

module spq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_head_valid,
  input logic [spq_pkg::KEY_W-1:0]     out_head_key,
  input logic [spq_pkg::PAY_W-1:0]     out_head_payload,
  input logic                          out_insert_dropped
);
  import spq_pkg::*;

  `SPQ_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted beat did not raise busy")
  `SPQ_ASSERT_NEXT(a_result_latency, clk, rst_n, start && !busy, ##3 out_valid, "result beat not on time")
  `SPQ_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && !out_head_valid, (out_head_key == '0) && (out_head_payload == '0), "empty queue reports nonzero head")
  `SPQ_ASSERT_NOW(a_drop_full, clk, rst_n, out_valid && out_insert_dropped, out_head_valid, "dropped insert with empty queue")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_head_valid     (out_head_valid),
  .out_head_key       (out_head_key),
  .out_head_payload   (out_head_payload),
  .out_insert_dropped (out_insert_dropped)
);
